@@ sv/sofd_pkg.sv @@
// Shared types and constants for the start-of-frame XOR deframer.
// No dependencies; used by the parser, the top level and the checker.
`default_nettype none

package sofd_pkg;

  localparam logic [7:0] SofByte    = 8'hFE;
  localparam logic [7:0] LimitReset = 8'd128;

  localparam logic KindPayload = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] function_code;
    logic [7:0]  payload_length;
    logic [6:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        checksum_good;
  } result_t;

  typedef struct packed {
    logic step;
    logic load;
  } ctrl_t;

endpackage

`default_nettype wire

@@ sv/sofd_parser.sv @@
// Frame parser: receive phase state machine, running XOR and the result register.
// Depends on sofd_pkg for the result and control structs and the start byte.
`default_nettype none

module sofd_parser #(
  parameter int unsigned MAX_PAYLOAD = 128
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sofd_pkg::ctrl_t  ctrl_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic [7:0]       limit_i,
  output logic                  res_valid_o,
  output sofd_pkg::result_t     res_o
);

  localparam logic [15:0] MaxPayloadW = 16'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PhWait,
    PhFuncHi,
    PhFuncLo,
    PhLenHi,
    PhLenLo,
    PhPayload,
    PhCheck
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [15:0]       func_q, func_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        cnt_q, cnt_d;
  logic [7:0]        csum_q, csum_d;
  logic              emit;
  logic              too_long;
  sofd_pkg::result_t res_d;
  sofd_pkg::result_t res_q;
  logic              res_valid_q;

  assign too_long = (len_q != 8'd0) || (rx_byte_i > limit_i) ||
                    ({8'd0, rx_byte_i} > MaxPayloadW);

  always_comb begin
    phase_d = phase_q;
    func_d  = func_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    csum_d  = csum_q ^ rx_byte_i;
    emit    = 1'b0;
    res_d.kind           = sofd_pkg::KindPayload;
    res_d.function_code  = func_q;
    res_d.payload_length = len_q;
    res_d.byte_index     = cnt_q[6:0];
    res_d.payload_byte   = rx_byte_i;
    res_d.checksum_good  = 1'b0;
    unique case (phase_q)
      PhWait: begin
        csum_d = csum_q;
        if (rx_byte_i == sofd_pkg::SofByte) begin
          func_d  = 16'd0;
          len_d   = 8'd0;
          cnt_d   = 8'd0;
          csum_d  = sofd_pkg::SofByte;
          phase_d = PhFuncHi;
        end
      end
      PhFuncHi: begin
        func_d  = {rx_byte_i, 8'd0};
        phase_d = PhFuncLo;
      end
      PhFuncLo: begin
        func_d  = {func_q[15:8], rx_byte_i};
        phase_d = PhLenHi;
      end
      PhLenHi: begin
        len_d   = rx_byte_i;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        cnt_d = 8'd0;
        if (too_long) begin
          len_d   = 8'd0;
          phase_d = PhWait;
        end else begin
          len_d   = rx_byte_i;
          phase_d = (rx_byte_i == 8'd0) ? PhCheck : PhPayload;
        end
      end
      PhPayload: begin
        emit  = 1'b1;
        cnt_d = cnt_q + 8'd1;
        if (cnt_d >= len_q) begin
          phase_d = PhCheck;
        end
      end
      PhCheck: begin
        emit    = 1'b1;
        csum_d  = csum_q;
        phase_d = PhWait;
        res_d.kind          = sofd_pkg::KindVerdict;
        res_d.byte_index    = 7'd0;
        res_d.payload_byte  = 8'd0;
        res_d.checksum_good = (rx_byte_i == csum_q);
      end
      default: begin
        csum_d  = csum_q;
        phase_d = PhWait;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhWait;
      func_q      <= 16'd0;
      len_q       <= 8'd0;
      cnt_q       <= 8'd0;
      csum_q      <= 8'd0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (ctrl_i.step) begin
        phase_q <= phase_d;
        func_q  <= func_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        csum_q  <= csum_d;
      end
      if (ctrl_i.load) begin
        res_valid_q <= ctrl_i.step && emit;
        if (ctrl_i.step && emit) begin
          res_q <= res_d;
        end
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ sv/sof_frame_xor_deframer_core.sv @@
// A result word passes through the input register and then the result register before
// it appears on the outputs; a stall on the result side can hold it in the input register.
// Throughput: one input word per cycle; the input register and the result register
// form a two-stage pipeline that advances whenever the result register is free.
// Reset (rst_ni low, asynchronous): the parser waits for a start byte, both stages
// are empty and the length limit returns to 128. Depends on sofd_pkg and sofd_parser.
`default_nettype none

module sof_frame_xor_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic [15:0]      function_code_o,
  output logic [7:0]       payload_length_o,
  output logic [6:0]       byte_index_o,
  output logic [7:0]       payload_byte_o,
  output logic             checksum_good_o
);

  logic [7:0]        max_len_q;
  logic              in_valid_q;
  logic [7:0]        rx_byte_q;
  logic              out_free;
  logic              res_valid;
  sofd_pkg::ctrl_t   ctrl;
  sofd_pkg::result_t res;

  assign out_free   = !res_valid || out_ready_i;
  assign ctrl.load  = out_free;
  assign ctrl.step  = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= sofd_pkg::LimitReset;
      in_valid_q <= 1'b0;
      rx_byte_q  <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
        rx_byte_q  <= rx_byte_i;
      end else if (ctrl.step) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  sofd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .rx_byte_i   (rx_byte_q),
    .limit_i     (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_o      = res_valid;
  assign result_kind_o    = res.kind;
  assign function_code_o  = res.function_code;
  assign payload_length_o = res.payload_length;
  assign byte_index_o     = res.byte_index;
  assign payload_byte_o   = res.payload_byte;
  assign checksum_good_o  = res.checksum_good;

endmodule

`default_nettype wire

@@ sv/sofd_checker.sv @@
// Port-level checker for the deframer top level, attached through a bind.
// Depends on sofd_pkg for the result kind codes.
`default_nettype none

module sofd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        result_kind_o,
  input wire logic [15:0] function_code_o,
  input wire logic [7:0]  payload_length_o,
  input wire logic [6:0]  byte_index_o,
  input wire logic [7:0]  payload_byte_o,
  input wire logic        checksum_good_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(function_code_o) && $stable(payload_length_o) &&
      $stable(byte_index_o) && $stable(payload_byte_o) && $stable(checksum_good_o))
    else $error("Result word changed while stalled.");

  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == sofd_pkg::KindVerdict |->
      byte_index_o == 7'd0 && payload_byte_o == 8'd0)
    else $error("Verdict word carries payload data.");

  a_payload_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == sofd_pkg::KindPayload |->
      !checksum_good_o && {1'b0, byte_index_o} < payload_length_o)
    else $error("Payload word index outside the declared length.");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input stalled while the result side was free.");

endmodule

bind sof_frame_xor_deframer_core sofd_checker u_sofd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .result_kind_o    (result_kind_o),
  .function_code_o  (function_code_o),
  .payload_length_o (payload_length_o),
  .byte_index_o     (byte_index_o),
  .payload_byte_o   (payload_byte_o),
  .checksum_good_o  (checksum_good_o)
);

`default_nettype wire
